// File: design/tprs_pkg.sv
// ----------------------------------------------------------------------------
// tprs_pkg
// Shared widths, constants and register codes for the timer prescaler and
// reload search core.
// ----------------------------------------------------------------------------
package tprs_pkg;

	// field widths
	localparam int DELAY_W    = 16;
	localparam int CPM_W      = 16;
	localparam int PRESC_W    = 12;
	localparam int RELOAD_W   = 16;
	localparam int NUM_W      = 32;
	localparam int DIVISOR_W  = PRESC_W + 1;

	// reset value of the clock-cycles-per-millisecond register
	localparam logic [CPM_W-1:0] CPM_RESET = 16'd13560;

	// reload must stay below this bound for a fit
	localparam logic [RELOAD_W-1:0] RELOAD_BOUND = 16'hFFFF;

	// threshold for prescaler 0 and its step per prescaler increment
	localparam logic [NUM_W-1:0] BOUND_START = 32'h0000_FFFF;
	localparam logic [NUM_W-1:0] BOUND_STEP  = 32'h0001_FFFE;

	// register word index decoded from paddr[2]
	localparam logic REG_CYCLES_PER_MS = 1'b0;

	// apb
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

endpackage

// File: design/timer_prescaler_reload_search_core.sv
// ----------------------------------------------------------------------------
// timer_prescaler_reload_search_core
// Turns a timeout in milliseconds into a timer prescaler and reload value.
// ----------------------------------------------------------------------------
// Usage:
//   An item on the s_ channel carries delay_ms. The core forms
//   delay_ms * cycles_per_ms - 1 (32-bit wrap), then finds the first
//   prescaler p below PRESCALER_LIMIT whose reload num / (2p+1) is below
//   0xFFFF, and returns prescaler, reload and fit_found on the m_ channel.
//   cycles_per_ms is an apb register at byte address 0 (reset 13560).
// Steps:
//   the bit-serial multiplier, then one prescaler candidate per cycle
//   (a running threshold 0xFFFF*(2p+1) compared against the
//   numerator, up to PRESCALER_LIMIT candidates), then the bit-serial
//   divider, then the output register. One item at a time: the next
//   item is taken only after the previous result is handed to the
//   output register.
// Reset:
//   arst_n clears control state and reloads cycles_per_ms; no clearing pass.
// Stall:
//   a result waits in the output register; s_tready returns high once the
//   result is handed to that register, so the next item can start while the
//   receiver still holds the previous one.
// ----------------------------------------------------------------------------
module timer_prescaler_reload_search_core
	import tprs_pkg::*;
#(
	parameter int PRESCALER_LIMIT = 4095
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// apb configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [15:0]            s_tdata,   // [15:0] delay_ms
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // [11:0] prescaler, [27:12] reload, zero pad
	output logic                   m_tuser    // [0] fit_found
);

	localparam logic [PRESC_W-1:0] P_LIMIT = PRESC_W'(PRESCALER_LIMIT);
	localparam logic [PRESC_W-1:0] P_LAST  = PRESC_W'(PRESCALER_LIMIT - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SRCH = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]            state_q;
	logic [CPM_W-1:0]      cpm_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      bound_q;
	logic [PRESC_W-1:0]    p_q;
	logic                  fit_q;
	logic                  div_start_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic                  m_tvalid_q;
	logic [PRESC_W-1:0]    m_presc_q;
	logic [RELOAD_W-1:0]   m_reload_q;
	logic                  m_fit_q;

	logic                  in_accept;
	logic                  cfg_write;
	logic                  mul_done;
	logic [NUM_W-1:0]      mul_product;
	logic                  div_done;
	logic [NUM_W-1:0]      div_quotient;
	logic                  out_free;

	assign in_accept = s_tvalid && s_tready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign out_free  = !m_tvalid_q || m_tready;

	// apb register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q <= CPM_RESET;
		end else if (cfg_write && (paddr[2] == REG_CYCLES_PER_MS)) begin
			cpm_q <= pwdata[CPM_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CYCLES_PER_MS) ?
		{{(APB_DATA_W-CPM_W){1'b0}}, cpm_q} : '0;

	// numerator multiplier
	tprs_mul_serial u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_accept),
		.a       (s_tdata[DELAY_W-1:0]),
		.b       (cpm_q),
		.done    (mul_done),
		.product (mul_product)
	);

	// reload divider
	tprs_div_serial u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (num_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// sequencer: multiply, search, divide, hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if ((num_q < bound_q) || (p_q == P_LAST)) begin
						state_q     <= ST_DIV;
						div_start_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search datapath: reload < 0xFFFF exactly when num < 0xFFFF*(2p+1)
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL && mul_done) begin
			num_q   <= mul_product - 1'b1;
			bound_q <= BOUND_START;
			p_q     <= '0;
		end else if (state_q == ST_SRCH) begin
			if (num_q < bound_q) begin
				fit_q     <= 1'b1;
				divisor_q <= {p_q, 1'b1};
			end else if (p_q == P_LAST) begin
				fit_q     <= 1'b0;
				divisor_q <= {p_q, 1'b1};
				p_q       <= P_LIMIT;
			end else begin
				p_q     <= p_q + 1'b1;
				bound_q <= bound_q + BOUND_STEP;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_presc_q  <= p_q;
			m_reload_q <= div_quotient[RELOAD_W-1:0];
			m_fit_q    <= fit_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(32-PRESC_W-RELOAD_W){1'b0}}, m_reload_q, m_presc_q};
	assign m_tuser  = m_fit_q;

endmodule

// File: design/tprs_mul_serial.sv
// ----------------------------------------------------------------------------
// tprs_mul_serial
// Shift-add multiplier, one multiplier bit per cycle, 16 x 16 to 32 bits.
// ----------------------------------------------------------------------------
module tprs_mul_serial
	import tprs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DELAY_W-1:0]   a,
	input  logic [CPM_W-1:0]     b,
	output logic                 done,
	output logic [NUM_W-1:0]     product
);

	localparam int CNT_W = $clog2(CPM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CPM_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   mcand_q;
	logic [CPM_W-1:0]   mplier_q;
	logic [NUM_W-1:0]   prod_q;

	// control: step through the multiplier bits, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: add shifted multiplicand when the low multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{(NUM_W-DELAY_W){1'b0}}, a};
			mplier_q <= b;
			prod_q   <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[CPM_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

// File: design/tprs_div_serial.sv
// ----------------------------------------------------------------------------
// tprs_div_serial
// Restoring divider, one quotient bit per cycle, 32-bit dividend by a
// 13-bit divisor.
// ----------------------------------------------------------------------------
module tprs_div_serial
	import tprs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [NUM_W-1:0]      quo_q;
	logic [DIVISOR_W:0]    rem_shift;
	logic [DIVISOR_W+1:0]  trial;

	// shift in the next dividend bit and try the subtraction
	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, div_q};

	// control: step through the quotient bits, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend register turns into the quotient as it shifts
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[DIVISOR_W+1]) begin
				rem_q <= trial[DIVISOR_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[DIVISOR_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: bench/tb_timer_prescaler_reload_search_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_prescaler_reload_search_core
// Self-checking bench for the timer prescaler and reload search core.
// A stream driver feeds millisecond delays in random bursts, a monitor takes
// results under a rotating back-pressure pattern and compares each one with
// a behavioral search of the same prescaler and reload. The clock-per-ms
// register is rewritten over apb between phases and read back each time.
// ----------------------------------------------------------------------------
module tb_timer_prescaler_reload_search_core;
	import tprs_pkg::*;

	localparam int PRESC_LIMIT = 4095;
	localparam logic [APB_ADDR_W-1:0] ADDR_CYCLES_PER_MS = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED      = 3'd4;
	localparam int DRAIN_CYCLES  = PRESC_LIMIT + 60;
	localparam int MAX_REPORTS   = 40;

	// one result item, lowest field last
	typedef struct packed {
		logic                fit_found;
		logic [RELOAD_W-1:0] reload;
		logic [PRESC_W-1:0]  prescaler;
	} timer_setting_t;

	typedef struct {
		logic [DELAY_W-1:0] delay_ms;
		logic [CPM_W-1:0]   cycles_per_ms;
		timer_setting_t     setting;
	} awaited_setting_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata  = '0;   // [15:0] delay_ms
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;         // [11:0] prescaler, [27:12] reload, zero pad
	logic                  m_tuser;         // [0] fit_found

	logic [CPM_W-1:0]      cpm_model = CPM_RESET;
	logic [DELAY_W-1:0]    delay_backlog[$];
	awaited_setting_t      awaited_settings[$];

	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	logic [15:0] ready_pattern;
	logic [3:0]  ready_idx;

	int mismatch_count = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int fits_seen      = 0;
	int misses_seen    = 0;
	int settings_used  = 1;

	timer_prescaler_reload_search_core #(
		.PRESCALER_LIMIT(PRESC_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// linear search over prescaler candidates
	function automatic timer_setting_t search_timer_setting(
		input logic [DELAY_W-1:0] delay_ms,
		input logic [CPM_W-1:0]   cycles_per_ms
	);
		logic [NUM_W-1:0] numerator;
		logic [NUM_W-1:0] quotient;
		int unsigned      presc;
		logic             fit;
		timer_setting_t   found;
		numerator = NUM_W'(delay_ms) * NUM_W'(cycles_per_ms) - NUM_W'(1);
		quotient  = '0;
		presc     = 0;
		fit       = 1'b0;
		while (presc < PRESC_LIMIT && !fit) begin
			quotient = numerator / NUM_W'(2 * presc + 1);
			if (quotient < NUM_W'(RELOAD_BOUND))
				fit = 1'b1;
			else
				presc++;
		end
		found.prescaler = presc[PRESC_W-1:0];
		found.reload    = quotient[RELOAD_W-1:0];
		found.fit_found = fit;
		return found;
	endfunction

	// mostly short timeouts so searches stay brief, some across the full range
	function automatic logic [DELAY_W-1:0] pick_delay();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return DELAY_W'($urandom_range(0, 255));
		else if (roll < 8)
			return DELAY_W'($urandom_range(0, 4095));
		return DELAY_W'($urandom_range(0, 65535));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want, input logic [DELAY_W-1:0] delay_ms,
		input logic [CPM_W-1:0] cycles_per_ms);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s got 0x%0h want 0x%0h (delay_ms %0d, cycles_per_ms %0d)",
				$realtime, what, got, want, delay_ms, cycles_per_ms);
		mismatch_count++;
	endtask

	// apb write, model follows at the access edge
	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr[2] == REG_CYCLES_PER_MS)
			cpm_model = data[CPM_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// apb read of the clock-per-ms register, sampled mid access phase
	task automatic check_register();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_CYCLES_PER_MS;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== APB_DATA_W'(cpm_model))
			report_mismatch("cycles_per_ms readback", prdata, APB_DATA_W'(cpm_model),
				'0, cpm_model);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// new register value with junk in the unused upper bits
	task automatic set_cycles_per_ms(input logic [CPM_W-1:0] value);
		apb_write(ADDR_CYCLES_PER_MS, {16'($urandom()), value});
		check_register();
		settings_used++;
	endtask

	// wait until every item is taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (delay_backlog.size() != 0 || s_tvalid || awaited_settings.size() != 0);
	endtask

	task automatic random_phase(input logic [CPM_W-1:0] value, input int count);
		set_cycles_per_ms(value);
		@(negedge clk);
		repeat (count)
			delay_backlog.push_back(pick_delay());
		drain();
	endtask

	// driver: bursts of items separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				awaited_settings.push_back('{s_tdata, cpm_model,
					search_timer_setting(s_tdata, cpm_model)});
				items_sent++;
			end
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 6);
				gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				s_tvalid   <= 1'b0;
			end else if (delay_backlog.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= delay_backlog.pop_front();
				burst_left--;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver back-pressure from a rotating 16-bit ready pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready      <= 1'b0;
			ready_pattern <= 16'hFFFF;
			ready_idx     <= '0;
		end else begin
			m_tready  <= ready_pattern[ready_idx];
			ready_idx <= ready_idx + 4'd1;
			if (ready_idx == 4'd15) begin
				case ($urandom_range(0, 3))
					0: ready_pattern <= 16'hFFFF;
					1: ready_pattern <= 16'h8000;
					default: ready_pattern <= 16'($urandom());
				endcase
			end
		end
	end

	// monitor: compare each result item with the oldest awaited setting
	always @(posedge clk) begin
		awaited_setting_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (awaited_settings.size() == 0) begin
				report_mismatch("result with nothing awaited", m_tdata, '0, '0, cpm_model);
			end else begin
				want = awaited_settings.pop_front();
				if (want.setting.fit_found)
					fits_seen++;
				else
					misses_seen++;
				if (m_tdata[11:0] !== want.setting.prescaler)
					report_mismatch("prescaler", 32'(m_tdata[11:0]),
						32'(want.setting.prescaler), want.delay_ms, want.cycles_per_ms);
				if (m_tdata[27:12] !== want.setting.reload)
					report_mismatch("reload", 32'(m_tdata[27:12]),
						32'(want.setting.reload), want.delay_ms, want.cycles_per_ms);
				if (m_tuser !== want.setting.fit_found)
					report_mismatch("fit_found", 32'(m_tuser),
						32'(want.setting.fit_found), want.delay_ms, want.cycles_per_ms);
			end
		end
	end

	// main sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_register();

		// reset setting: zero delay, fit at the first candidate and just past it,
		// no-fit boundary, full scale and alternating bits
		@(negedge clk);
		delay_backlog.push_back(16'd0);
		delay_backlog.push_back(16'd1);
		delay_backlog.push_back(16'd4);
		delay_backlog.push_back(16'd5);
		delay_backlog.push_back(16'd39577);
		delay_backlog.push_back(16'd39578);
		delay_backlog.push_back(16'hFFFF);
		delay_backlog.push_back(16'h5555);
		delay_backlog.push_back(16'hAAAA);
		drain();

		// numerator lands exactly on the reload bound
		set_cycles_per_ms(16'd256);
		@(negedge clk);
		delay_backlog.push_back(16'd255);
		delay_backlog.push_back(16'd256);
		delay_backlog.push_back(16'd257);
		drain();

		// write to an unmapped register leaves the setting alone
		apb_write(ADDR_UNMAPPED, $urandom());
		check_register();
		@(negedge clk);
		delay_backlog.push_back(16'd256);
		drain();

		// largest product, and zero delay at the top setting
		set_cycles_per_ms(16'hFFFF);
		@(negedge clk);
		delay_backlog.push_back(16'hFFFF);
		delay_backlog.push_back(16'd0);
		delay_backlog.push_back(16'd1);
		drain();

		// zero clocks per ms wraps like a zero delay
		set_cycles_per_ms(16'd0);
		@(negedge clk);
		delay_backlog.push_back(16'd7);
		delay_backlog.push_back(16'd0);
		drain();

		// smallest legal setting
		set_cycles_per_ms(16'd1);
		@(negedge clk);
		delay_backlog.push_back(16'hFFFF);
		delay_backlog.push_back(16'd1);
		delay_backlog.push_back(16'd0);
		drain();

		// random phases over several settings
		random_phase(CPM_W'($urandom_range(1, 65535)), 24);
		random_phase(16'd1, 24);
		random_phase(16'hFFFF, 24);
		random_phase(CPM_W'($urandom_range(1, 2000)), 24);
		random_phase(CPM_RESET, 24);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d delays over %0d clock-per-ms settings", items_sent, settings_used);
		$display("%0d results checked: %0d with a fit, %0d without", results_seen, fits_seen,
			misses_seen);
		if (mismatch_count == 0 && awaited_settings.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("timeout with %0d results outstanding", awaited_settings.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
design/tprs_pkg.sv
design/tprs_mul_serial.sv
design/tprs_div_serial.sv
design/timer_prescaler_reload_search_core.sv
bench/tb_timer_prescaler_reload_search_core.sv
